[rtl/core/spa_pkg.sv]
package spa_pkg;

   localparam int SEGMENTS      = 64;
   localparam int SEGMENT_SHIFT = 12;
   localparam int ADDRESS_WIDTH = 32;

   localparam int IDX_W = $clog2(SEGMENTS);
   localparam int CNT_W = $clog2(SEGMENTS + 1);

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_BAD_ADDR   = 2'd2,
      ST_NOT_IN_USE = 2'd3
   } status_type;

   typedef enum logic {
      ACT_REQUEST = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

endpackage

[rtl/core/spa_ram.sv]
module spa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/segment_pool_allocator.sv]
// A request beat is accepted in idle, where the free-index FIFO RAM and the
// in-use RAM are read; the exec state updates them and loads the response
// register. No request is taken in exec or while a response beat is stalled.
// Reset: synchronous, active high; the pool is all free and base is zero at once,
// per-entry written bits stand in for RAM contents, so there is no clearing pass.
module segment_pool_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [31:0]                        csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [spa_pkg::ADDRESS_WIDTH-1:0]  req_address,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [spa_pkg::ADDRESS_WIDTH-1:0]  rsp_segment_address,
   output logic [spa_pkg::CNT_W-1:0]          rsp_free_count
);

   localparam int AW   = spa_pkg::ADDRESS_WIDTH;
   localparam int IW   = spa_pkg::IDX_W;
   localparam int CW   = spa_pkg::CNT_W;
   localparam int SEGS = spa_pkg::SEGMENTS;
   localparam int SH   = spa_pkg::SEGMENT_SHIFT;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   spa_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [AW-1:0]          rsp_addr_ff, rsp_addr_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;
   logic [AW-1:0]          base_ff, base_in;
   logic [IW-1:0]          head_ff, head_in;
   logic [IW-1:0]          tail_ff, tail_in;
   logic [CW-1:0]          total_ff, total_in;
   logic [SEGS-1:0]        fifo_written_ff, fifo_written_in;
   logic [SEGS-1:0]        inuse_written_ff, inuse_written_in;
   spa_pkg::action_type    action_ff, action_in;
   logic                   bad_ff, bad_in;
   logic [IW-1:0]          idx_ff, idx_in;

   logic                   req_accept;
   logic [AW-1:0]          offset;
   logic                   req_bad;
   logic [IW-1:0]          req_idx;

   logic [IW-1:0]          fifo_rd;
   logic                   fifo_we;
   logic                   inuse_rd;
   logic                   inuse_we;
   logic [IW-1:0]          inuse_waddr;
   logic                   inuse_wdata;
   logic [IW-1:0]          grant_idx;
   logic                   inuse_now;

   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] p);
      return (p == IW'(SEGS - 1)) ? '0 : p + 1'b1;
   endfunction

   assign req_stall  = (state_ff != S_IDLE) | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;

   assign offset  = req_address - base_ff;
   assign req_idx = offset[SH +: IW];
   assign req_bad = (offset[SH-1:0] != '0) || ((offset >> SH) >= AW'(SEGS));

   assign grant_idx = fifo_written_ff[head_ff] ? fifo_rd : head_ff;
   assign inuse_now = inuse_written_ff[idx_ff] & inuse_rd;

   spa_ram #(.WIDTH(IW), .DEPTH(SEGS)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (idx_ff),
      .rd_addr (head_ff),
      .rd_data (fifo_rd)
   );

   spa_ram #(.WIDTH(1), .DEPTH(SEGS)) u_inuse_ram (
      .clock   (clock),
      .wr_en   (inuse_we),
      .wr_addr (inuse_waddr),
      .wr_data (inuse_wdata),
      .rd_addr (req_idx),
      .rd_data (inuse_rd)
   );

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_addr_in      = rsp_addr_ff;
      rsp_count_in     = rsp_count_ff;
      base_in          = base_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      total_in         = total_ff;
      fifo_written_in  = fifo_written_ff;
      inuse_written_in = inuse_written_ff;
      action_in        = action_ff;
      bad_in           = bad_ff;
      idx_in           = idx_ff;
      fifo_we          = 1'b0;
      inuse_we         = 1'b0;
      inuse_waddr      = idx_ff;
      inuse_wdata      = 1'b0;

      if (csr_write_enable) begin
         base_in = AW'(csr_write_data);
      end
      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               action_in = spa_pkg::action_type'(req_action);
               bad_in    = req_bad;
               idx_in    = req_idx;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_addr_in  = '0;
            if (action_ff == spa_pkg::ACT_REQUEST) begin
               if (total_ff == '0) begin
                  rsp_status_in = spa_pkg::ST_EMPTY;
               end else begin
                  rsp_status_in = spa_pkg::ST_OK;
                  rsp_addr_in   = base_ff + (AW'(grant_idx) << SH);
                  head_in       = next_slot(head_ff);
                  total_in      = total_ff - 1'b1;
                  inuse_we      = 1'b1;
                  inuse_waddr   = grant_idx;
                  inuse_wdata   = 1'b1;
                  inuse_written_in[grant_idx] = 1'b1;
               end
            end else if (bad_ff) begin
               rsp_status_in = spa_pkg::ST_BAD_ADDR;
            end else if (!inuse_now) begin
               rsp_status_in = spa_pkg::ST_NOT_IN_USE;
            end else begin
               rsp_status_in = spa_pkg::ST_OK;
               inuse_we      = 1'b1;
               inuse_waddr   = idx_ff;
               inuse_wdata   = 1'b0;
               inuse_written_in[idx_ff] = 1'b1;
               fifo_we       = 1'b1;
               fifo_written_in[tail_ff] = 1'b1;
               tail_in       = next_slot(tail_ff);
               if (total_ff < CW'(SEGS)) begin
                  total_in = total_ff + 1'b1;
               end
            end
            rsp_count_in = total_in;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         base_ff          <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         total_ff         <= CW'(SEGS);
         fifo_written_ff  <= '0;
         inuse_written_ff <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         base_ff          <= base_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         total_ff         <= total_in;
         fifo_written_ff  <= fifo_written_in;
         inuse_written_ff <= inuse_written_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
      action_ff     <= action_in;
      bad_ff        <= bad_in;
      idx_ff        <= idx_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_segment_address = rsp_addr_ff;
   assign rsp_free_count      = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(SEGS))
      else $error("free total above pool size");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      ((CW + 1)'(head_ff) + (CW + 1)'(total_ff) >= (CW + 1)'(SEGS)) ?
         ((CW + 1)'(tail_ff) == (CW + 1)'(head_ff) + (CW + 1)'(total_ff) - (CW + 1)'(SEGS)) :
         ((CW + 1)'(tail_ff) == (CW + 1)'(head_ff) + (CW + 1)'(total_ff)))
      else $error("head, tail and free total disagree");

   a_exec_gives_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> rsp_valid_ff && rsp_count_ff == total_ff)
      else $error("update cycle did not load a response beat");

   a_fail_keeps_pool: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC && rsp_status_in != spa_pkg::ST_OK |=>
         $stable(head_ff) && $stable(tail_ff) && $stable(total_ff))
      else $error("failed beat changed the pool");
`endif

endmodule

[verif/tb_top.sv]
module tb_top;

   localparam int SEG_BYTES    = 1 << spa_pkg::SEGMENT_SHIFT;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int CSR_SETTLE   = 2;
   localparam int MAX_REPORTS  = 10;

   typedef logic [spa_pkg::ADDRESS_WIDTH-1:0] addr_type;

   typedef struct packed {
      spa_pkg::status_type       status;
      addr_type                  segment_address;
      logic [spa_pkg::CNT_W-1:0] free_count;
   } pool_answer_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_write_enable;
   logic [31:0]  csr_write_data;
   logic         req_valid;
   logic         req_stall;
   logic         req_action;
   addr_type     req_address;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [1:0]   rsp_status;
   addr_type     rsp_segment_address;
   logic [spa_pkg::CNT_W-1:0] rsp_free_count;

   // pool shadow
   logic [spa_pkg::IDX_W-1:0]    free_ring [spa_pkg::SEGMENTS];
   int                           ring_head;
   int                           ring_tail;
   logic [spa_pkg::CNT_W-1:0]    free_segments;
   logic [spa_pkg::SEGMENTS-1:0] segment_busy;
   addr_type                     pool_base;

   pool_answer_type answers_due[$];
   int mismatches     = 0;
   int idle_cycles    = 0;
   int sender_gap_pct = 20;
   int sink_stall_pct = 60;

   segment_pool_allocator uut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_address         (req_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_segment_address (rsp_segment_address),
      .rsp_free_count      (rsp_free_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < sink_stall_pct);
   end

   task automatic reset_pool_shadow();
      for (int i = 0; i < spa_pkg::SEGMENTS; i++) begin
         free_ring[i] = spa_pkg::IDX_W'(i);
      end
      ring_head     = 0;
      ring_tail     = 0;
      free_segments = spa_pkg::CNT_W'(spa_pkg::SEGMENTS);
      segment_busy  = '0;
      pool_base     = '0;
   endtask

   function automatic pool_answer_type allocate_or_free(spa_pkg::action_type act,
                                                        addr_type addr);
      pool_answer_type ans;
      addr_type offset;
      int idx;
      ans.status = spa_pkg::ST_OK;
      ans.segment_address = '0;
      if (act == spa_pkg::ACT_REQUEST) begin
         if (free_segments == 0) begin
            ans.status = spa_pkg::ST_EMPTY;
         end else begin
            idx = int'(free_ring[ring_head]);
            ring_head = (ring_head + 1) % spa_pkg::SEGMENTS;
            free_segments = free_segments - 1'b1;
            segment_busy[idx] = 1'b1;
            ans.segment_address = pool_base + (addr_type'(idx) << spa_pkg::SEGMENT_SHIFT);
         end
      end else begin
         offset = addr - pool_base;
         if (offset[spa_pkg::SEGMENT_SHIFT-1:0] != 0 ||
             (offset >> spa_pkg::SEGMENT_SHIFT) >= spa_pkg::SEGMENTS) begin
            ans.status = spa_pkg::ST_BAD_ADDR;
         end else begin
            idx = int'(offset >> spa_pkg::SEGMENT_SHIFT);
            if (!segment_busy[idx]) begin
               ans.status = spa_pkg::ST_NOT_IN_USE;
            end else begin
               segment_busy[idx] = 1'b0;
               free_ring[ring_tail] = spa_pkg::IDX_W'(idx);
               ring_tail = (ring_tail + 1) % spa_pkg::SEGMENTS;
               if (free_segments < spa_pkg::SEGMENTS) free_segments = free_segments + 1'b1;
            end
         end
      end
      ans.free_count = free_segments;
      return ans;
   endfunction

   function automatic addr_type segment_start(int idx);
      return pool_base + (addr_type'(idx) << spa_pkg::SEGMENT_SHIFT);
   endfunction

   // mostly live segments, then free ones, misaligned, out of pool and noise
   function automatic addr_type pick_release_address();
      int roll;
      int idx;
      roll = $urandom_range(99);
      idx  = $urandom_range(spa_pkg::SEGMENTS - 1);
      if (roll < 70) begin
         for (int k = 0; k < spa_pkg::SEGMENTS && !segment_busy[idx]; k++)
            idx = (idx + 1) % spa_pkg::SEGMENTS;
         return segment_start(idx);
      end else if (roll < 80) begin
         return segment_start(idx);
      end else if (roll < 88) begin
         return segment_start(idx) + addr_type'($urandom_range(1, SEG_BYTES - 1));
      end else if (roll < 91) begin
         return segment_start(spa_pkg::SEGMENTS + $urandom_range(spa_pkg::SEGMENTS));
      end else if (roll < 94) begin
         return pool_base - (addr_type'($urandom_range(1, spa_pkg::SEGMENTS))
                             << spa_pkg::SEGMENT_SHIFT);
      end
      return addr_type'($urandom);
   endfunction

   task automatic send_item(spa_pkg::action_type act, addr_type addr);
      @(negedge clock);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_action  = act;
      req_address = addr;
      do @(posedge clock); while (req_stall);
      answers_due.push_back(allocate_or_free(act, addr));
   endtask

   task automatic write_base(addr_type value);
      @(negedge clock);
      req_valid = 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (CSR_SETTLE) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      pool_base = value;
   endtask

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %s: expected 0x%08h got 0x%08h", what, want, got);
   endtask

   always @(posedge clock) begin
      pool_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            note_mismatch("beat with nothing pending, status", 32'd0, 32'(rsp_status));
         end else begin
            want = answers_due.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_segment_address !== want.segment_address)
               note_mismatch("segment_address", want.segment_address, rsp_segment_address);
            if (rsp_free_count !== want.free_count)
               note_mismatch("free_count", 32'(want.free_count), 32'(rsp_free_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("segment_pool_allocator regression: fail");
         $finish;
      end
   end

   task automatic test_after_reset();
      send_item(spa_pkg::ACT_RELEASE, 32'h0000_0000);
      send_item(spa_pkg::ACT_REQUEST, 32'h0000_0000);
      send_item(spa_pkg::ACT_REQUEST, 32'hFFFF_FFFF);
      send_item(spa_pkg::ACT_RELEASE, 32'h0000_1000);
      send_item(spa_pkg::ACT_RELEASE, 32'h0000_1000);
      send_item(spa_pkg::ACT_REQUEST, 32'h0000_0000);
   endtask

   task automatic test_address_checks();
      send_item(spa_pkg::ACT_RELEASE, 32'h0000_0001);
      send_item(spa_pkg::ACT_RELEASE, addr_type'(SEG_BYTES / 2));
      send_item(spa_pkg::ACT_RELEASE, segment_start(spa_pkg::SEGMENTS));
      send_item(spa_pkg::ACT_RELEASE, 32'hFFFF_FFFF);
      send_item(spa_pkg::ACT_RELEASE, segment_start(spa_pkg::SEGMENTS - 1));
      send_item(spa_pkg::ACT_RELEASE, 32'hFFFF_F000);
      send_item(spa_pkg::ACT_REQUEST, 32'hFFFF_FFFF);
   endtask

   task automatic test_base_wrap();
      write_base(~addr_type'(SEG_BYTES - 1));
      send_item(spa_pkg::ACT_REQUEST, 32'h0000_0000);
      send_item(spa_pkg::ACT_RELEASE, segment_start(4));
      send_item(spa_pkg::ACT_RELEASE, segment_start(0));
      send_item(spa_pkg::ACT_RELEASE, pool_base - addr_type'(SEG_BYTES));
      write_base('1);
      send_item(spa_pkg::ACT_REQUEST, 32'h0000_0000);
      send_item(spa_pkg::ACT_RELEASE, segment_start(1));
      send_item(spa_pkg::ACT_RELEASE, segment_start(2));
      send_item(spa_pkg::ACT_RELEASE, 32'h0000_0000);
   endtask

   task automatic test_pool_exhaustion();
      int idx;
      write_base(addr_type'($urandom));
      while (free_segments != 0) send_item(spa_pkg::ACT_REQUEST, addr_type'($urandom));
      send_item(spa_pkg::ACT_REQUEST, addr_type'($urandom));
      send_item(spa_pkg::ACT_REQUEST, addr_type'($urandom));
      repeat (3) begin
         idx = $urandom_range(spa_pkg::SEGMENTS - 1);
         send_item(spa_pkg::ACT_RELEASE, segment_start(idx));
         send_item(spa_pkg::ACT_RELEASE, segment_start(idx));
      end
      send_item(spa_pkg::ACT_REQUEST, addr_type'($urandom));
   endtask

   // request bias switches so the pool swings between full and empty
   task automatic test_random_traffic(int items);
      int req_pct;
      req_pct = 50;
      for (int n = 0; n < items; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0: req_pct = 90;
               1: req_pct = 50;
               default: req_pct = 10;
            endcase
         end
         if ($urandom_range(99) < req_pct) begin
            send_item(spa_pkg::ACT_REQUEST, addr_type'($urandom));
         end else begin
            send_item(spa_pkg::ACT_RELEASE, pick_release_address());
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_action       = spa_pkg::ACT_REQUEST;
      req_address      = '0;
      reset_pool_shadow();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_address_checks();
      test_base_wrap();
      test_pool_exhaustion();
      write_base(addr_type'($urandom));
      test_random_traffic(470);

      sender_gap_pct = 60;
      sink_stall_pct = 20;
      write_base(addr_type'($urandom));
      test_random_traffic(470);

      sender_gap_pct = 0;
      sink_stall_pct = 0;
      write_base('0);
      test_random_traffic(470);

      @(negedge clock);
      req_valid = 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("segment_pool_allocator regression: pass");
      end else begin
         $display("segment_pool_allocator regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/spa_pkg.sv
rtl/core/spa_ram.sv
rtl/core/segment_pool_allocator.sv
verif/tb_top.sv
